/* sv/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg: shared types and constants for the configuration frame ECC block
// Holds the field widths, the index band limits and the queue item format.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // Field widths.
    localparam int INDEX_W  = 7;
    localparam int WORD_W   = 32;
    localparam int CHECK_W  = 13;
    localparam int UPPER_W  = WORD_W - CHECK_W;

    // Default frame length and queue depth.
    localparam int FRAME_WORDS_DEF = 101;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Index of the word that carries the ECC field.
    localparam logic [INDEX_W-1:0] ECC_INDEX = 7'h32;

    // Upper limits of the lower two index bands.
    localparam logic [INDEX_W-1:0] BAND0_LAST = 7'h06;
    localparam logic [INDEX_W-1:0] BAND1_LAST = 7'h25;

    // Band bases shifted down by five: each base is a multiple of 32.
    localparam logic [7:0] BASE0_HI = 8'(32'h1320 >> 5);
    localparam logic [7:0] BASE1_HI = 8'(32'h1340 >> 5);
    localparam logic [7:0] BASE2_HI = 8'(32'h1360 >> 5);

    // Mask that keeps the upper part of the ECC word.
    localparam logic [WORD_W-1:0] ECC_FIELD_KEEP = 32'hFFFF_E000;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic [CHECK_W-1:0] contrib;    // XOR of all positions of set bits
        logic               is_parity;  // fold overall parity after this word
        logic               is_ecc;     // capture the upper ECC bits
        logic [UPPER_W-1:0] ecc_upper;  // bits 31..13 of the word
        logic               last;       // emit a result after this word
    } t_cfe_item;

endpackage

/* sv/cfe_in_if.sv */
// ----------------------------------------------------------------------------
// cfe_in_if: frame word channel
// Carries one frame word with its index and last-word mark per request.
// ----------------------------------------------------------------------------
interface cfe_in_if
    import cfe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  frame_word;
    logic               last_word;

    modport source (output valid, output word_index, output frame_word,
                    output last_word, input ready);
    modport sink   (input valid, input word_index, input frame_word,
                    input last_word, output ready);
endinterface

/* sv/cfe_out_if.sv */
// ----------------------------------------------------------------------------
// cfe_out_if: frame result channel
// Carries the check value and the patched ECC word, one request per frame.
// ----------------------------------------------------------------------------
interface cfe_out_if
    import cfe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHECK_W-1:0] check_value;
    logic [WORD_W-1:0]  patched_ecc_word;

    modport source (output valid, output check_value, output patched_ecc_word,
                    input ready);
    modport sink   (input valid, input check_value, input patched_ecc_word,
                    output ready);
endinterface

/* sv/cfe_front.sv */
// ----------------------------------------------------------------------------
// cfe_front: word classifier
// Masks the ECC field, reduces the word to its check contribution and marks
// the parity, ECC and last-word cases for the back end.
// ----------------------------------------------------------------------------
module cfe_front
    import cfe_pkg::*;
#(
    parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
    input  logic [INDEX_W-1:0] i_word_index,
    input  logic [WORD_W-1:0]  i_frame_word,
    input  logic               i_last_word,
    output t_cfe_item          o_item
);

    localparam logic [INDEX_W-1:0] PARITY_INDEX = INDEX_W'(FRAME_WORDS - 1);

    logic              w_is_ecc;
    logic [WORD_W-1:0] w_data;
    logic [7:0]        w_base_hi;
    logic [7:0]        w_pos_hi;
    logic [4:0]        w_low_xor;
    logic              w_odd;

    // The ECC word has its check field cleared before it is counted.
    assign w_is_ecc = (i_word_index == ECC_INDEX);
    assign w_data   = w_is_ecc ? (i_frame_word & ECC_FIELD_KEEP) : i_frame_word;

    // Band base, in units of 32 bit positions.
    always_comb begin
        priority if (i_word_index > BAND1_LAST) begin
            w_base_hi = BASE2_HI;
        end else if (i_word_index > BAND0_LAST) begin
            w_base_hi = BASE1_HI;
        end else begin
            w_base_hi = BASE0_HI;
        end
    end

    // Upper eight position bits, wrapping modulo 8192.
    assign w_pos_hi = 8'({1'b0, i_word_index} + w_base_hi);

    // The base has five clear low bits, so each position is the upper part
    // joined to the bit number. The upper part survives only for an odd
    // count of set bits; the low part is the XOR of the set bit numbers.
    always_comb begin
        w_low_xor = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (w_data[b]) begin
                w_low_xor = w_low_xor ^ 5'(b);
            end
        end
    end

    assign w_odd = ^w_data;

    // Assemble the queue item.
    always_comb begin
        o_item.contrib   = {(w_odd ? w_pos_hi : 8'h00), w_low_xor};
        o_item.is_parity = (i_word_index == PARITY_INDEX);
        o_item.is_ecc    = w_is_ecc;
        o_item.ecc_upper = i_frame_word[WORD_W-1:CHECK_W];
        o_item.last      = i_last_word;
    end

endmodule

/* sv/cfe_queue.sv */
// ----------------------------------------------------------------------------
// cfe_queue: short item queue
// Decouples the classifier from the accumulator so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module cfe_queue
    import cfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cfe_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cfe_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cfe_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/cfe_back.sv */
// ----------------------------------------------------------------------------
// cfe_back: check accumulator and result register
// Folds each item into the running check value and presents the frame
// result in an output register.
// ----------------------------------------------------------------------------
module cfe_back
    import cfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cfe_item          i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CHECK_W-1:0] o_check_value,
    output logic [WORD_W-1:0]  o_patched_ecc_word
);

    logic [CHECK_W-1:0] r_acc;
    logic [UPPER_W-1:0] r_held;
    logic               r_out_valid;
    logic [CHECK_W-1:0] r_check;
    logic [WORD_W-1:0]  r_patched;
    logic [CHECK_W-1:0] n_acc;
    logic [UPPER_W-1:0] n_held;
    logic [CHECK_W-1:0] w_sum;

    // A word without result always moves on; a last word waits for room.
    assign o_pop = i_valid && (!i_item.last || !r_out_valid || i_ready);

    // Next running check with the optional parity fold into bit 12.
    always_comb begin
        w_sum = r_acc ^ i_item.contrib;
        n_acc = w_sum;
        if (i_item.is_parity) begin
            n_acc[CHECK_W-1] = w_sum[CHECK_W-1] ^ (^w_sum[CHECK_W-2:0]);
        end
        n_held = i_item.is_ecc ? i_item.ecc_upper : r_held;
    end

    // Running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (o_pop) begin
            r_acc  <= i_item.last ? '0 : n_acc;
            r_held <= n_held;
        end
    end

    // Result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_check   <= n_acc;
            r_patched <= {n_held, n_acc};
        end
    end

    assign o_valid            = r_out_valid;
    assign o_check_value      = r_check;
    assign o_patched_ecc_word = r_patched;

endmodule

/* sv/config_frame_ecc.sv */
// ----------------------------------------------------------------------------
// config_frame_ecc: Hamming check value over one configuration frame
// Classifier, short queue and accumulator with a registered result.
// ----------------------------------------------------------------------------
// Frame words arrive on i_in, one request per word, carrying the word index,
// the 32-bit data and a last-word mark. Each word is reduced to its share of
// the 13-bit check value by the front classifier and is then queued.
// The back end folds the queued shares into the running check, applies the
// overall parity at index FRAME_WORDS-1 and captures the ECC word's upper
// bits. A word with the last-word mark produces one request on o_out with
// the check value and the ECC word with its low 13 bits patched.
// Throughput is one word per cycle while the queue has room; a result is valid
// once its last word has passed the queue entry and then the output register.
// Reset clears the queue, the running check, the held ECC bits and the
// output valid flag. While the receiver stalls, words without the last-word
// mark are still absorbed; a last word waits in the queue, and i_in.ready
// drops once the queue of QUEUE_DEPTH entries is full.
// ----------------------------------------------------------------------------
module config_frame_ecc
    import cfe_pkg::*;
#(
    parameter int FRAME_WORDS = FRAME_WORDS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfe_in_if.sink      i_in,
    cfe_out_if.source   o_out
);

    t_cfe_item w_front_item;
    t_cfe_item w_head_item;
    logic      w_full;
    logic      w_head_valid;
    logic      w_pop;

    // Front: classify the incoming word.
    cfe_front #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_front (
        .i_word_index (i_in.word_index),
        .i_frame_word (i_in.frame_word),
        .i_last_word  (i_in.last_word),
        .o_item       (w_front_item)
    );

    assign i_in.ready = !w_full;

    // Queue between the two halves.
    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head_item)
    );

    // Back: accumulate and deliver the result.
    cfe_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_head_valid),
        .i_item             (w_head_item),
        .o_pop              (w_pop),
        .o_valid            (o_out.valid),
        .i_ready            (o_out.ready),
        .o_check_value      (o_out.check_value),
        .o_patched_ecc_word (o_out.patched_ecc_word)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the configuration frame ECC block
// Streams frame words with random gaps, predicts each check value and patched
// ECC word, and compares every result request on the output channel with the
// oldest prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import cfe_pkg::*;

    // Index at which the overall parity is folded into bit 12.
    localparam logic [INDEX_W-1:0] PARITY_INDEX = INDEX_W'(FRAME_WORDS_DEF - 1);

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic [WORD_W-1:0]  data;
        logic               last;
    } frame_word_t;

    typedef struct {
        logic [CHECK_W-1:0] check;
        logic [WORD_W-1:0]  patched;
    } frame_result_t;

    logic clk;
    logic rst_n;

    cfe_in_if  in_ch ();
    cfe_out_if out_ch ();

    config_frame_ecc dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    frame_word_t        pending_words[$];
    frame_result_t      expected_results[$];
    logic [CHECK_W-1:0] frame_check;
    logic [UPPER_W-1:0] held_upper;
    int                 word_total;
    int                 frame_total;
    int                 error_count;
    logic [31:0]        cycle_count;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Idle cycles before the next request; one stretch in four has none.
    function automatic int draw_gap();
        if (cycle_count[8:7] == 2'b11)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // XOR of the positions of all set bits of one word at its index.
    function automatic logic [CHECK_W-1:0] word_share(logic [INDEX_W-1:0] idx,
                                                     logic [WORD_W-1:0] data);
        logic [CHECK_W-1:0] base;
        logic [CHECK_W-1:0] pos;
        logic [CHECK_W-1:0] acc;
        if (idx > BAND1_LAST)
            base = {BASE2_HI, 5'b0};
        else if (idx > BAND0_LAST)
            base = {BASE1_HI, 5'b0};
        else
            base = {BASE0_HI, 5'b0};
        pos = CHECK_W'({idx, 5'b0}) + base;
        acc = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (data[b])
                acc ^= pos + CHECK_W'(b);
        end
        return acc;
    endfunction

    // Fold one accepted word into the running check and predict a result.
    task automatic account_word(frame_word_t w);
        logic [WORD_W-1:0]  data;
        logic [CHECK_W-1:0] acc;
        frame_result_t      r;
        data = w.data;
        if (w.idx == ECC_INDEX) begin
            held_upper = data[WORD_W-1:CHECK_W];
            data &= ECC_FIELD_KEEP;
        end
        acc = frame_check ^ word_share(w.idx, data);
        if (w.idx == PARITY_INDEX)
            acc[CHECK_W-1] = acc[CHECK_W-1] ^ (^acc[CHECK_W-2:0]);
        if (w.last) begin
            r.check   = acc;
            r.patched = {held_upper, acc};
            expected_results.push_back(r);
            frame_check = '0;
        end else begin
            frame_check = acc;
        end
    endtask

    task automatic push_word(int idx, logic [WORD_W-1:0] data, logic last);
        frame_word_t w;
        w.idx  = INDEX_W'(idx);
        w.data = data;
        w.last = last;
        pending_words.push_back(w);
        word_total++;
        if (last)
            frame_total++;
    endtask

    // Data words lean towards the all-zero and all-one extremes now and then.
    function automatic logic [WORD_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One random frame: mostly short well-formed frames, some full ones,
    // and some broken runs of arbitrary indices.
    task automatic queue_random_frame();
        int kind;
        int idx;
        int prev;
        int len;
        int n;
        bit want_ecc;
        int idxs[$];
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            for (idx = 0; idx < FRAME_WORDS_DEF; idx++)
                push_word(idx, pick_data(), idx == FRAME_WORDS_DEF - 1);
        end else if (kind < 8) begin
            idx      = $urandom_range(0, 60);
            len      = $urandom_range(1, 16);
            want_ecc = $urandom_range(0, 1);
            prev     = -1;
            while (idx <= 100 && idxs.size() < len) begin
                if (want_ecc && prev < ECC_INDEX && idx > ECC_INDEX)
                    idxs.push_back(ECC_INDEX);
                idxs.push_back(idx);
                prev = idx;
                idx += $urandom_range(1, 9);
            end
            if ($urandom_range(0, 2) == 0 && prev < PARITY_INDEX)
                idxs.push_back(PARITY_INDEX);
            for (n = 0; n < idxs.size(); n++)
                push_word(idxs[n], pick_data(), n == idxs.size() - 1);
        end else begin
            len = $urandom_range(1, 6);
            for (n = 0; n < len; n++)
                push_word($urandom_range(0, 127), $urandom, $urandom_range(0, 5) == 0);
        end
    endtask

    // Driver: presents the oldest pending word after a random gap.
    int   in_gap;
    logic in_holding;

    always @(posedge clk) begin : word_driver
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap      = 0;
            in_holding  = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                account_word(pending_words.pop_front());
                in_holding = 1'b0;
                in_gap     = draw_gap();
            end
            if (!in_holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_words.size() > 0) begin
                    in_ch.word_index <= pending_words[0].idx;
                    in_ch.frame_word <= pending_words[0].data;
                    in_ch.last_word  <= pending_words[0].last;
                    in_holding = 1'b1;
                end
            end
            in_ch.valid <= in_holding;
        end
    end

    // Monitor: checks each result request and stalls the receiver at random.
    int out_gap;

    always @(posedge clk) begin : result_monitor
        frame_result_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, check_value %h, patched_ecc_word %h",
                             $time, out_ch.check_value, out_ch.patched_ecc_word);
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.check_value !== want.check) begin
                        error_count++;
                        $display("%0t: check_value mismatch, expected %h, actual %h",
                                 $time, want.check, out_ch.check_value);
                    end
                    if (out_ch.patched_ecc_word !== want.patched) begin
                        error_count++;
                        $display("%0t: patched_ecc_word mismatch, expected %h, actual %h",
                                 $time, want.patched, out_ch.patched_ecc_word);
                    end
                end
                out_gap = draw_gap();
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        rst_n            = 1'b0;
        cycle_count      = '0;
        in_ch.valid      = 1'b0;
        in_ch.word_index = '0;
        in_ch.frame_word = '0;
        in_ch.last_word  = 1'b0;
        out_ch.ready     = 1'b0;
        frame_check      = '0;
        held_upper       = '0;
        word_total       = 0;
        frame_total      = 0;
        error_count      = 0;

        // An all-zero one-word frame straight after reset, then an all-ones word.
        push_word(0, 32'h0000_0000, 1'b1);
        push_word(0, 32'hFFFF_FFFF, 1'b1);
        // Both sides of each boundary between index bands.
        push_word(6, 32'h8000_0001, 1'b0);
        push_word(7, 32'h8000_0001, 1'b0);
        push_word(37, 32'h8000_0001, 1'b0);
        push_word(38, 32'h8000_0001, 1'b1);
        // The ECC word as the last word of its frame.
        push_word(ECC_INDEX, 32'hFFFF_FFFF, 1'b1);
        // Parity fold on the last word, and on a word that is not last.
        push_word(ECC_INDEX, 32'hA5A5_5A5A, 1'b0);
        push_word(PARITY_INDEX, 32'hFFFF_FFFF, 1'b1);
        push_word(PARITY_INDEX, 32'h1234_5678, 1'b0);
        push_word(3, 32'h0000_0001, 1'b1);
        // Indices beyond the frame.
        push_word(101, 32'hFFFF_FFFF, 1'b0);
        push_word(127, 32'hFFFF_FFFF, 1'b1);
        // Repeated and descending indices, no ECC word: held bits persist.
        push_word(10, 32'hDEAD_BEEF, 1'b0);
        push_word(10, 32'hDEAD_BEEF, 1'b0);
        push_word(5, 32'h0000_0001, 1'b1);
        // ECC word with only its masked low bits set.
        push_word(ECC_INDEX, 32'h0000_1FFF, 1'b0);
        push_word(60, 32'h0000_0000, 1'b1);
        push_word(64, 32'h5555_5555, 1'b0);
        push_word(PARITY_INDEX, 32'hAAAA_AAAA, 1'b1);

        while (word_total < 1000 || frame_total < 48)
            queue_random_frame();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* config_frame_ecc.f */
sv/cfe_pkg.sv
sv/cfe_in_if.sv
sv/cfe_out_if.sv
sv/cfe_front.sv
sv/cfe_queue.sv
sv/cfe_back.sv
sv/config_frame_ecc.sv
tb/tb.sv
